// ===== rtl/core/slt_pkg.sv =====
// ----------------------------------------------------------------------------
// slt_pkg: shared types and constants for the sorted list table
// Sizes, operation and status codes, controller states and the command and
// status bundles that join the controller to the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package slt_pkg;

   // Table sizes
   localparam int CAPACITY    = 64;
   localparam int VALUE_WIDTH = 32;
   localparam int ADDR_W      = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int COUNT_W     = 7;
   localparam int OPCODE_W    = 2;
   localparam int STATUS_W    = 2;
   localparam int REQ_DATA_W  = 32;
   localparam int RSP_DATA_W  = 16;

   // Flip the sign bit so that signed order becomes unsigned order
   localparam logic [VALUE_WIDTH-1:0] SIGN_FLIP = {1'b1, {(VALUE_WIDTH-1){1'b0}}};

   typedef enum logic [OPCODE_W-1:0] {
      OP_INSERT = 2'd0,
      OP_REMOVE = 2'd1,
      OP_LOOKUP = 2'd2
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_DONE      = 2'd0,
      ST_FULL      = 2'd1,
      ST_NOT_FOUND = 2'd2
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_SCAN_RD,
      S_SCAN_EV,
      S_DECIDE,
      S_UP_RD,
      S_UP_WR,
      S_PUT,
      S_DN_RD,
      S_DN_WR,
      S_RESP
   } state_type;

   // Cursor updates
   typedef enum logic [2:0] {
      CUR_HOLD,
      CUR_CLEAR,
      CUR_INC,
      CUR_DEC,
      CUR_TOP,
      CUR_AFTER_POS
   } cur_op_type;

   // Table writes
   typedef enum logic [1:0] {
      WR_NONE,
      WR_UP,
      WR_DOWN,
      WR_PUT
   } wr_op_type;

   typedef struct packed {
      logic       load_req;
      cur_op_type cur_op;
      wr_op_type  wr_op;
      logic       pos_at_cur;
      logic       pos_at_end;
      logic       set_status;
      logic       used_inc;
      logic       used_dec;
      logic       load_rsp;
   } cmd_type;

   typedef struct packed {
      op_type op;
      logic   used_zero;
      logic   full;
      logic   scan_less;
      logic   cur_last;
      logic   pos_lt_used;
      logic   hit;
      logic   cur_at_pos;
      logic   dn_has_more;
      logic   rsp_free;
   } stat_type;

endpackage

`default_nettype wire

// ===== rtl/core/slt_ram.sv =====
// ----------------------------------------------------------------------------
// slt_ram: generic single-write, single-read RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
`default_nettype none

module slt_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  wire logic                                       clock,
   input  wire logic                                       wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                           wr_data,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                           rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== rtl/core/slt_ctrl.sv =====
// ----------------------------------------------------------------------------
// slt_ctrl: sequencer for the sorted list table
// Walks each transaction through scan, decision, shift and response steps
// and drives the datapath with one command bundle per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module slt_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_tvalid,
   output logic                   req_tready,
   input  wire slt_pkg::stat_type stat,
   output slt_pkg::cmd_type       cmd
);

   slt_pkg::state_type state_ff;
   slt_pkg::state_type state_in;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         slt_pkg::S_IDLE: begin
            if (req_tvalid) begin
               state_in = stat.used_zero ? slt_pkg::S_DECIDE : slt_pkg::S_SCAN_RD;
            end
         end
         slt_pkg::S_SCAN_RD: begin
            state_in = slt_pkg::S_SCAN_EV;
         end
         slt_pkg::S_SCAN_EV: begin
            if (stat.scan_less && !stat.cur_last) begin
               state_in = slt_pkg::S_SCAN_RD;
            end else begin
               state_in = slt_pkg::S_DECIDE;
            end
         end
         slt_pkg::S_DECIDE: begin
            state_in = slt_pkg::S_RESP;
            if (stat.op == slt_pkg::OP_INSERT) begin
               if (!stat.full) begin
                  state_in = stat.pos_lt_used ? slt_pkg::S_UP_RD : slt_pkg::S_PUT;
               end
            end else if (stat.op == slt_pkg::OP_REMOVE) begin
               if (stat.hit && stat.dn_has_more) begin
                  state_in = slt_pkg::S_DN_RD;
               end
            end
         end
         slt_pkg::S_UP_RD: begin
            state_in = slt_pkg::S_UP_WR;
         end
         slt_pkg::S_UP_WR: begin
            state_in = stat.cur_at_pos ? slt_pkg::S_PUT : slt_pkg::S_UP_RD;
         end
         slt_pkg::S_PUT: begin
            state_in = slt_pkg::S_RESP;
         end
         slt_pkg::S_DN_RD: begin
            state_in = slt_pkg::S_DN_WR;
         end
         slt_pkg::S_DN_WR: begin
            state_in = stat.cur_last ? slt_pkg::S_RESP : slt_pkg::S_DN_RD;
         end
         slt_pkg::S_RESP: begin
            if (stat.rsp_free) begin
               state_in = slt_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = slt_pkg::S_IDLE;
         end
      endcase
   end

   // Outputs
   always_comb begin
      cmd            = '0;
      cmd.cur_op     = slt_pkg::CUR_HOLD;
      cmd.wr_op      = slt_pkg::WR_NONE;
      req_tready     = 1'b0;
      unique case (state_ff)
         slt_pkg::S_IDLE: begin
            req_tready   = 1'b1;
            cmd.load_req = req_tvalid;
            cmd.cur_op   = slt_pkg::CUR_CLEAR;
         end
         slt_pkg::S_SCAN_RD: begin
         end
         slt_pkg::S_SCAN_EV: begin
            if (!stat.scan_less) begin
               cmd.pos_at_cur = 1'b1;
            end else if (stat.cur_last) begin
               cmd.pos_at_end = 1'b1;
            end else begin
               cmd.cur_op = slt_pkg::CUR_INC;
            end
         end
         slt_pkg::S_DECIDE: begin
            cmd.set_status = 1'b1;
            if (stat.op == slt_pkg::OP_INSERT) begin
               if (!stat.full && stat.pos_lt_used) begin
                  cmd.cur_op = slt_pkg::CUR_TOP;
               end
            end else if (stat.op == slt_pkg::OP_REMOVE && stat.hit) begin
               if (stat.dn_has_more) begin
                  cmd.cur_op = slt_pkg::CUR_AFTER_POS;
               end else begin
                  cmd.used_dec = 1'b1;
               end
            end
         end
         slt_pkg::S_UP_RD: begin
         end
         slt_pkg::S_UP_WR: begin
            cmd.wr_op = slt_pkg::WR_UP;
            if (!stat.cur_at_pos) begin
               cmd.cur_op = slt_pkg::CUR_DEC;
            end
         end
         slt_pkg::S_PUT: begin
            cmd.wr_op    = slt_pkg::WR_PUT;
            cmd.used_inc = 1'b1;
         end
         slt_pkg::S_DN_RD: begin
         end
         slt_pkg::S_DN_WR: begin
            cmd.wr_op = slt_pkg::WR_DOWN;
            if (stat.cur_last) begin
               cmd.used_dec = 1'b1;
            end else begin
               cmd.cur_op = slt_pkg::CUR_INC;
            end
         end
         slt_pkg::S_RESP: begin
            cmd.load_rsp = stat.rsp_free;
         end
         default: begin
         end
      endcase
   end

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= slt_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/slt_dpath.sv =====
// ----------------------------------------------------------------------------
// slt_dpath: storage and arithmetic of the sorted list table
// Holds the entry RAM, cursor, insert position, occupancy and the result
// register; reports compare results to the controller.
// ----------------------------------------------------------------------------
`default_nettype none

module slt_dpath (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire slt_pkg::cmd_type                    cmd,
   output slt_pkg::stat_type                        stat,
   input  wire logic [slt_pkg::OPCODE_W-1:0]        req_tuser,
   input  wire logic [slt_pkg::REQ_DATA_W-1:0]      req_tdata,
   input  wire logic                                rsp_tready,
   output logic                                     rsp_tvalid,
   output logic      [slt_pkg::RSP_DATA_W-1:0]      rsp_tdata
);

   localparam int AW = slt_pkg::ADDR_W;
   localparam int CW = slt_pkg::COUNT_W;
   localparam int VW = slt_pkg::VALUE_WIDTH;
   localparam logic [CW-1:0] CAP = CW'(slt_pkg::CAPACITY);

   slt_pkg::op_type     op_ff, op_in;
   logic [VW-1:0]       key_ff, key_in;
   logic [AW-1:0]       cur_ff, cur_in;
   logic [CW-1:0]       pos_ff, pos_in;
   logic                hit_ff, hit_in;
   logic [CW-1:0]       used_ff, used_in;
   slt_pkg::status_type status_ff, status_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_found_ff, rsp_found_in;
   slt_pkg::status_type rsp_status_ff, rsp_status_in;
   logic [CW-1:0]       rsp_occ_ff, rsp_occ_in;

   logic                wr_en;
   logic [AW-1:0]       wr_addr;
   logic [VW-1:0]       wr_data;
   logic [VW-1:0]       rd_data;
   logic [CW-1:0]       cur_wide;
   logic [CW-1:0]       cur_p1;
   logic [CW-1:0]       pos_p1;
   logic [CW-1:0]       used_m1;
   logic                rsp_free;

   assign cur_wide = CW'(cur_ff);
   assign cur_p1   = cur_wide + CW'(1);
   assign pos_p1   = pos_ff + CW'(1);
   assign used_m1  = used_ff - CW'(1);
   assign rsp_free = !rsp_valid_ff || rsp_tready;

   // Entry store, read always at the cursor
   slt_ram #(
      .WIDTH (VW),
      .DEPTH (slt_pkg::CAPACITY)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (cur_ff),
      .rd_data (rd_data)
   );

   // Write address and data
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = cur_ff;
      wr_data = rd_data;
      case (cmd.wr_op)
         slt_pkg::WR_UP: begin
            wr_en   = 1'b1;
            wr_addr = cur_ff + AW'(1);
         end
         slt_pkg::WR_DOWN: begin
            wr_en   = 1'b1;
            wr_addr = cur_ff - AW'(1);
         end
         slt_pkg::WR_PUT: begin
            wr_en   = 1'b1;
            wr_addr = pos_ff[AW-1:0];
            wr_data = key_ff;
         end
         default: begin
         end
      endcase
   end

   // Capture the request
   always_comb begin
      op_in  = op_ff;
      key_in = key_ff;
      if (cmd.load_req) begin
         op_in  = slt_pkg::op_type'(req_tuser);
         key_in = req_tdata[VW-1:0] ^ slt_pkg::SIGN_FLIP;
      end
   end

   // Advance the cursor
   always_comb begin
      cur_in = cur_ff;
      case (cmd.cur_op)
         slt_pkg::CUR_CLEAR:     cur_in = '0;
         slt_pkg::CUR_INC:       cur_in = cur_ff + AW'(1);
         slt_pkg::CUR_DEC:       cur_in = cur_ff - AW'(1);
         slt_pkg::CUR_TOP:       cur_in = used_m1[AW-1:0];
         slt_pkg::CUR_AFTER_POS: cur_in = pos_p1[AW-1:0];
         default:                cur_in = cur_ff;
      endcase
   end

   // Record the insert position and match
   always_comb begin
      pos_in = pos_ff;
      hit_in = hit_ff;
      if (cmd.load_req) begin
         pos_in = '0;
         hit_in = 1'b0;
      end else if (cmd.pos_at_cur) begin
         pos_in = cur_wide;
         hit_in = (rd_data == key_ff);
      end else if (cmd.pos_at_end) begin
         pos_in = used_ff;
         hit_in = 1'b0;
      end
   end

   // Work out the status
   always_comb begin
      status_in = status_ff;
      if (cmd.set_status) begin
         case (op_ff)
            slt_pkg::OP_INSERT: begin
               status_in = (used_ff == CAP) ? slt_pkg::ST_FULL : slt_pkg::ST_DONE;
            end
            default: begin
               status_in = hit_ff ? slt_pkg::ST_DONE : slt_pkg::ST_NOT_FOUND;
            end
         endcase
      end
   end

   // Occupancy
   always_comb begin
      used_in = used_ff;
      if (cmd.used_inc) begin
         used_in = used_ff + CW'(1);
      end else if (cmd.used_dec) begin
         used_in = used_m1;
      end
   end

   // Result register
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_found_in  = rsp_found_ff;
      rsp_status_in = rsp_status_ff;
      rsp_occ_in    = rsp_occ_ff;
      if (cmd.load_rsp) begin
         rsp_valid_in  = 1'b1;
         rsp_found_in  = hit_ff;
         rsp_status_in = status_ff;
         rsp_occ_in    = used_ff;
      end else if (rsp_tready) begin
         rsp_valid_in  = 1'b0;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         used_ff      <= used_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      key_ff        <= key_in;
      cur_ff        <= cur_in;
      pos_ff        <= pos_in;
      hit_ff        <= hit_in;
      status_ff     <= status_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_status_ff <= rsp_status_in;
      rsp_occ_ff    <= rsp_occ_in;
   end

   // Status to the controller
   always_comb begin
      stat.op          = op_ff;
      stat.used_zero   = (used_ff == '0);
      stat.full        = (used_ff == CAP);
      stat.scan_less   = (rd_data < key_ff);
      stat.cur_last    = (cur_p1 == used_ff);
      stat.pos_lt_used = (pos_ff < used_ff);
      stat.hit         = hit_ff;
      stat.cur_at_pos  = (cur_wide == pos_ff);
      stat.dn_has_more = (pos_p1 < used_ff);
      stat.rsp_free    = rsp_free;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(slt_pkg::RSP_DATA_W - CW - slt_pkg::STATUS_W - 1){1'b0}},
                        rsp_occ_ff, rsp_status_ff, rsp_found_ff};

`ifndef SYNTH
   a_used_bounded: assert property (@(posedge clock) disable iff (reset)
      used_ff <= CAP)
      else $error("occupancy beyond capacity");

   a_no_grow_full: assert property (@(posedge clock) disable iff (reset)
      cmd.used_inc |-> (used_ff < CAP) && (pos_ff <= used_ff))
      else $error("insert into a full table or past the end");

   a_no_shrink_empty: assert property (@(posedge clock) disable iff (reset)
      cmd.used_dec |-> (used_ff != '0) && hit_ff)
      else $error("remove without a matching entry");

   a_rsp_slot_free: assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |-> rsp_free)
      else $error("result overwritten before it was taken");

   a_put_once: assert property (@(posedge clock) disable iff (reset)
      cmd.used_inc |=> !cmd.used_inc && !cmd.used_dec)
      else $error("occupancy changed twice in one transaction");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/sorted_list_table.sv =====
// ----------------------------------------------------------------------------
// sorted_list_table: bounded ascending store of signed values
// Insert, remove and lookup on a table of up to CAPACITY values, duplicates
// allowed, with one result per request.
// ----------------------------------------------------------------------------
// Usage:
//   Send a request on req_*: req_tuser carries the operation (insert,
//   remove, lookup), req_tdata the signed value. A transaction is taken on
//   a cycle with req_tvalid and req_tready both high.
//   Exactly one result per request leaves on rsp_*: found flag, status and
//   the occupancy after the operation.
//   One request is worked on at a time. The table sits in a RAM with one
//   write port and a registered read port; the scan reads and compares
//   the entries one at a time, and an insert or remove shifts each entry
//   it moves with a read and then a write. The next request is taken in
//   the cycle after the result is loaded into the output register.
//   The result waits in an output register; while it is not taken the
//   block still accepts and works on the next request, and holds that
//   result back until the register is free.
//   Reset empties the table at once (occupancy zero, no clearing pass).
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_list_table (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_tvalid,
   output logic                                req_tready,
   input  wire logic [slt_pkg::REQ_DATA_W-1:0] req_tdata,  // [31:0] value
   input  wire logic [slt_pkg::OPCODE_W-1:0]   req_tuser,  // [1:0] opcode
   output logic                                rsp_tvalid,
   input  wire logic                           rsp_tready,
   output logic      [slt_pkg::RSP_DATA_W-1:0] rsp_tdata   // [0] found, [2:1] status,
                                                           // [9:3] occupancy, rest zero
);

   slt_pkg::cmd_type  cmd;
   slt_pkg::stat_type stat;

   // Sequencer
   slt_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   // Storage and compare
   slt_dpath u_dpath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

`default_nettype wire
